// ===== rtl/core/gbba_pkg.sv =====
// Package for the grouped block bitmap allocator.
// Sizes, status codes and register indexes; no dependencies.
package gbba_pkg;

  localparam int GROUPS          = 8;
  localparam int BITS_PER_GROUP  = 8192;
  localparam int WORDS_PER_GROUP = (BITS_PER_GROUP + 31) / 32;
  localparam int GROUP_W         = $clog2(GROUPS);
  localparam int WORD_W          = $clog2(WORDS_PER_GROUP);
  localparam int ADDR_W          = GROUP_W + WORD_W;
  localparam int OFF_W           = $clog2(BITS_PER_GROUP);
  localparam int BPG_W           = 14;
  localparam int GCNT_W          = 4;
  localparam int BLK_W           = 16;
  localparam int TOT_W           = 17;
  localparam int AU_W            = 18;

  localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_RANGE        = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_BLOCKS_PER_GROUP = 2'd0,
    CFG_FIRST_DATA_BLOCK = 2'd1,
    CFG_BLOCKS_TOTAL     = 2'd2,
    CFG_GROUP_COUNT      = 2'd3
  } cfg_idx_t;

endpackage

// ===== rtl/core/grouped_block_bitmap_allocator.sv =====
// Grouped block bitmap allocator: sequencer, bitmap RAM and one shared add/sub unit.
// Depends on gbba_pkg.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------
//  in      | input     | in_valid/in_stall  | kind, block_number
//  out     | output    | out_valid/out_stall| status, allocated_block, used_total
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Free: range check against first_data_block and blocks_total, the quotient search
//   one group step at a time (up to 8 steps), bitmap read-modify-write, result.
// Allocate: groups are tried in order; each group with room has its bitmap words
//   scanned (one RAM word per cycle) for the lowest clear bit, then the result.
// Reset starts a clearing pass over all 2048 bitmap RAM words; no transaction is taken
//   on the input meanwhile, configuration writes are.
// One request at a time; the input stalls until the result transaction completes.
module grouped_block_bitmap_allocator
  import gbba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 kind,
  input  logic [BLK_W-1:0]     block_number,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status,
  output logic [BLK_W-1:0]     allocated_block,
  output logic [TOT_W-1:0]     used_total,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [TOT_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_F_LO, S_F_HI, S_DIV, S_FRD, S_FRW,
    S_GRP, S_SCAN, S_NXT, S_GADD, S_OUT
  } state_t;

  state_t state;

  logic [BPG_W-1:0]  blocks_per_group;
  logic [BLK_W-1:0]  first_data_block;
  logic [TOT_W-1:0]  blocks_total;
  logic [GCNT_W-1:0] group_count;

  logic [BPG_W-1:0]  group_used [GROUPS];
  logic [TOT_W-1:0]  total;

  logic [ADDR_W-1:0] clr_addr;
  logic [GCNT_W-1:0] g;
  logic [BLK_W-1:0]  rem;
  logic [OFF_W-1:0]  off;
  logic [TOT_W-1:0]  base;
  logic [WORD_W-1:0] w_issue;
  logic [BPG_W-1:0]  issue_left;
  logic              chk_valid;
  logic [WORD_W-1:0] chk_w;
  logic [BPG_W-1:0]  chk_left;

  logic [31:0]       mem [GROUPS * WORDS_PER_GROUP];
  logic [31:0]       rd_data;
  logic [ADDR_W-1:0] mem_raddr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [31:0]       mem_wdata;

  logic [BPG_W-1:0]  bpg;
  logic [GCNT_W-1:0] ng;
  logic              au_sub;
  logic [TOT_W-1:0]  au_a;
  logic [TOT_W-1:0]  au_b;
  logic [AU_W-1:0]   au_res;
  logic              au_lt;

  logic [31:0]       mask;
  logic [31:0]       inv;
  logic              hit;
  logic [4:0]        hit_bit;
  logic              chk_last;
  logic [31:0]       bit_m;
  logic [TOT_W-1:0]  tot_inc;
  logic [TOT_W-1:0]  tot_dec;

  always_comb begin
    if (blocks_per_group == '0) begin
      bpg = BPG_W'(1);
    end else if (blocks_per_group > BPG_W'(BITS_PER_GROUP)) begin
      bpg = BPG_W'(BITS_PER_GROUP);
    end else begin
      bpg = blocks_per_group;
    end
    ng = (group_count > GCNT_W'(GROUPS)) ? GCNT_W'(GROUPS) : group_count;
  end

  // shared add/subtract unit
  always_comb begin
    au_sub = 1'b1;
    au_a   = '0;
    au_b   = '0;
    unique case (state)
      S_F_LO: begin
        au_a = TOT_W'(rem);
        au_b = TOT_W'(first_data_block);
      end
      S_F_HI: begin
        au_a = TOT_W'(rem);
        au_b = blocks_total;
      end
      S_DIV: begin
        au_a = TOT_W'(rem);
        au_b = TOT_W'(bpg);
      end
      S_GRP: begin
        au_a = TOT_W'(group_used[g[GROUP_W-1:0]]);
        au_b = TOT_W'(bpg);
      end
      S_NXT: begin
        au_sub = 1'b0;
        au_a   = base;
        au_b   = TOT_W'(bpg);
      end
      S_GADD: begin
        au_sub = 1'b0;
        au_a   = base;
        au_b   = TOT_W'(off);
      end
      default: begin
        au_sub = 1'b1;
      end
    endcase
    au_res = au_sub ? ({1'b0, au_a} - {1'b0, au_b}) : ({1'b0, au_a} + {1'b0, au_b});
    au_lt  = au_res[AU_W-1];
  end

  // lowest clear bit of the word under check
  always_comb begin
    if (chk_left < BPG_W'(32)) begin
      mask = (32'h1 << chk_left[4:0]) - 32'h1;
    end else begin
      mask = '1;
    end
    inv      = ~rd_data & mask;
    hit      = chk_valid && (inv != '0);
    chk_last = chk_left <= BPG_W'(32);
    hit_bit  = '0;
    for (int i = 31; i >= 0; i--) begin
      if (inv[i]) begin
        hit_bit = 5'(i);
      end
    end
    bit_m   = (state == S_FRW) ? (32'h1 << off[4:0]) : (32'h1 << hit_bit);
    tot_inc = (total == TOTAL_MAX) ? total : total + TOT_W'(1);
    tot_dec = (total == '0) ? total : total - TOT_W'(1);
  end

  always_comb begin
    mem_raddr = {g[GROUP_W-1:0], w_issue};
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    unique case (state)
      S_CLR: begin
        mem_we = 1'b1;
      end
      S_FRD: begin
        mem_raddr = {g[GROUP_W-1:0], off[OFF_W-1:5]};
      end
      S_FRW: begin
        mem_waddr = {g[GROUP_W-1:0], off[OFF_W-1:5]};
        mem_we    = rd_data[off[4:0]];
        mem_wdata = rd_data & ~bit_m;
      end
      S_SCAN: begin
        mem_waddr = {g[GROUP_W-1:0], chk_w};
        mem_we    = hit;
        mem_wdata = rd_data | bit_m;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLR;
      clr_addr         <= '0;
      blocks_per_group <= BPG_W'(8192);
      first_data_block <= BLK_W'(1);
      blocks_total     <= TOT_W'(65536);
      group_count      <= GCNT_W'(8);
      total            <= '0;
      chk_valid        <= 1'b0;
      for (int i = 0; i < GROUPS; i++) begin
        group_used[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_BLOCKS_PER_GROUP: blocks_per_group <= cfg_data[BPG_W-1:0];
          CFG_FIRST_DATA_BLOCK: first_data_block <= cfg_data[BLK_W-1:0];
          CFG_BLOCKS_TOTAL:     blocks_total     <= cfg_data;
          CFG_GROUP_COUNT:      group_count      <= cfg_data[GCNT_W-1:0];
        endcase
      end

      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            g    <= '0;
            base <= '0;
            rem  <= block_number;
            state <= kind ? S_F_LO : S_GRP;
          end
        end
        S_F_LO: begin
          if (au_lt) begin
            status          <= ST_RANGE;
            allocated_block <= '0;
            used_total      <= total;
            state           <= S_OUT;
          end else begin
            state <= S_F_HI;
          end
        end
        S_F_HI: begin
          if (!au_lt) begin
            status          <= ST_RANGE;
            allocated_block <= '0;
            used_total      <= total;
            state           <= S_OUT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (au_lt) begin
            off   <= rem[OFF_W-1:0];
            state <= S_FRD;
          end else if (g == GCNT_W'(GROUPS - 1)) begin
            status          <= ST_RANGE;
            allocated_block <= '0;
            used_total      <= total;
            state           <= S_OUT;
          end else begin
            rem <= au_res[BLK_W-1:0];
            g   <= g + GCNT_W'(1);
          end
        end
        S_FRD: begin
          state <= S_FRW;
        end
        S_FRW: begin
          allocated_block <= '0;
          if (!rd_data[off[4:0]]) begin
            status     <= ST_ALREADY_FREE;
            used_total <= total;
          end else begin
            if (group_used[g[GROUP_W-1:0]] != '0) begin
              group_used[g[GROUP_W-1:0]] <= group_used[g[GROUP_W-1:0]] - BPG_W'(1);
            end
            total      <= tot_dec;
            status     <= ST_OK;
            used_total <= tot_dec;
          end
          state <= S_OUT;
        end
        S_GRP: begin
          // GROUPS * BITS_PER_GROUP spans the 16-bit block space, so every
          // offset below bpg has a representable block number
          if (g >= ng) begin
            status          <= ST_NO_FREE;
            allocated_block <= '0;
            used_total      <= total;
            state           <= S_OUT;
          end else if (!au_lt) begin
            state <= S_NXT;
          end else begin
            w_issue    <= '0;
            issue_left <= bpg;
            chk_valid  <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          chk_w     <= w_issue;
          chk_left  <= issue_left;
          if (issue_left != '0) begin
            w_issue    <= w_issue + WORD_W'(1);
            issue_left <= (issue_left > BPG_W'(32)) ? issue_left - BPG_W'(32) : '0;
          end
          if (hit) begin
            group_used[g[GROUP_W-1:0]] <= group_used[g[GROUP_W-1:0]] + BPG_W'(1);
            total      <= tot_inc;
            used_total <= tot_inc;
            off        <= {chk_w, hit_bit};
            chk_valid  <= 1'b0;
            state      <= S_GADD;
          end else if (chk_valid && chk_last) begin
            chk_valid <= 1'b0;
            state     <= S_NXT;
          end else begin
            chk_valid <= issue_left != '0;
          end
        end
        S_NXT: begin
          base  <= au_res[TOT_W-1:0];
          g     <= g + GCNT_W'(1);
          state <= S_GRP;
        end
        S_GADD: begin
          status          <= ST_OK;
          allocated_block <= au_res[BLK_W-1:0];
          state           <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = state != S_IDLE;
  assign out_valid = state == S_OUT;
  assign cfg_ready = 1'b1;

`ifndef ASSERT_OFF
  a_no_accept_with_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_reset_clears_first: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input open during the bitmap clearing pass");

  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> allocated_block == '0)
    else $error("failed request reports a block number");

  a_no_same_cycle_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid)
    else $error("result shown in the cycle after acceptance");
`endif

endmodule

// ===== tb/tb_grouped_block_bitmap_allocator.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for grouped_block_bitmap_allocator: directed and random
// allocate/free traffic against a shadow bitmap predictor. Depends on gbba_pkg and the RTL.
module tb_grouped_block_bitmap_allocator;
  import gbba_pkg::*;

  localparam logic KIND_ALLOC  = 1'b0;
  localparam logic KIND_FREE   = 1'b1;
  localparam int   HOLD_CYCLES = 400;
  localparam int   TAIL_CYCLES = 2200;
  localparam int   CYCLE_LIMIT = 10_000_000;

  typedef struct {
    status_t          st;
    logic [BLK_W-1:0] blk;
    logic [TOT_W-1:0] tot;
  } reply_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             req_kind = KIND_ALLOC;
  logic [BLK_W-1:0] req_block = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       status;
  logic [BLK_W-1:0] allocated_block;
  logic [TOT_W-1:0] used_total;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  logic [TOT_W-1:0] cfg_data = '0;

  // shadow registers and allocator state
  logic [BPG_W-1:0]          reg_bpg    = 14'd8192;
  logic [BLK_W-1:0]          reg_fdb    = 16'd1;
  logic [TOT_W-1:0]          reg_btotal = 17'd65536;
  logic [GCNT_W-1:0]         reg_gcount = 4'd8;
  bit [BITS_PER_GROUP-1:0]   used_map [GROUPS];
  int                        grp_used [GROUPS];
  int                        total_used_shadow = 0;

  reply_t awaited_replies [$];
  int     live_locs [$];
  int     freed_locs [$];

  int          mismatches = 0;
  int          replies_checked = 0;
  int          requests_sent = 0;
  int          settings_used = 1;
  int          status_tally [4];
  int          burst_left = 0;
  bit          gaps_enabled = 1'b1;
  int          holds_asked = 0;
  int          holds_granted = 0;
  int          hold_left = 0;
  int          stall_mode = 0;
  int          mode_left = 0;
  int          stall_tick = 0;
  int unsigned cycle_count = 0;

  grouped_block_bitmap_allocator u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(req_kind),
    .block_number(req_block),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .allocated_block(allocated_block),
    .used_total(used_total),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies pending", cycle_count,
               awaited_replies.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: changing stall patterns, plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_granted != holds_asked) begin
      holds_granted <= holds_granted + 1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      stall_tick <= stall_tick + 1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= 1'($urandom_range(0, 1));
        2: out_stall <= ($urandom_range(0, 4) == 0);
        default: out_stall <= ((stall_tick % 6) < 3);
      endcase
    end
  end

  function automatic int group_span();
    if (reg_bpg == 0) return 1;
    if (reg_bpg > BITS_PER_GROUP) return BITS_PER_GROUP;
    return int'(reg_bpg);
  endfunction

  function automatic logic [BLK_W-1:0] block_of(input int loc);
    int n;
    n = (loc / BITS_PER_GROUP) * group_span() + (loc % BITS_PER_GROUP);
    return n[BLK_W-1:0];
  endfunction

  // next allocator state and the reply for one accepted request
  task automatic apply_request(input logic k, input logic [BLK_W-1:0] blk, output reply_t r);
    int  span, ng, g, base, lim, off, loc, i;
    bit  done;
    span = group_span();
    r.st = ST_NO_FREE;
    r.blk = '0;
    done = 1'b0;
    if (k == KIND_ALLOC) begin
      ng = (int'(reg_gcount) > GROUPS) ? GROUPS : int'(reg_gcount);
      g = 0;
      while (g < ng && !done) begin
        base = g * span;
        if (grp_used[g] < span) begin
          if (base > 16'hFFFF) begin
            done = 1'b1;
          end else begin
            lim = 65536 - base;
            if (lim > span) lim = span;
            off = 0;
            while (off < lim && used_map[g][off]) off++;
            if (off < lim) begin
              used_map[g][off] = 1'b1;
              grp_used[g]++;
              if (total_used_shadow < TOTAL_MAX) total_used_shadow++;
              r.blk = BLK_W'(base + off);
              r.st = ST_OK;
              live_locs.push_back(g * BITS_PER_GROUP + off);
              done = 1'b1;
            end
          end
        end
        g++;
      end
    end else if (blk < reg_fdb || blk >= reg_btotal || blk / span >= GROUPS) begin
      r.st = ST_RANGE;
    end else begin
      g = blk / span;
      off = blk % span;
      if (!used_map[g][off]) begin
        r.st = ST_ALREADY_FREE;
      end else begin
        used_map[g][off] = 1'b0;
        if (grp_used[g] > 0) grp_used[g]--;
        if (total_used_shadow > 0) total_used_shadow--;
        r.st = ST_OK;
        loc = g * BITS_PER_GROUP + off;
        for (i = 0; i < live_locs.size() && !done; i++) begin
          if (live_locs[i] == loc) begin
            live_locs.delete(i);
            done = 1'b1;
          end
        end
        freed_locs.push_back(loc);
        if (freed_locs.size() > 32) void'(freed_locs.pop_front());
      end
    end
    r.tot = TOT_W'(total_used_shadow);
    status_tally[r.st]++;
  endtask

  task automatic note_mismatch(input string what, input int want_v, input int got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at reply %0d: expected %0d, got %0d", what, replies_checked,
               want_v, got_v);
  endtask

  always @(posedge clk) begin : check_replies
    reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_replies.size() == 0) begin
        note_mismatch("reply with nothing awaited (status)", -1, status);
      end else begin
        want = awaited_replies.pop_front();
        if (status !== want.st) note_mismatch("status", want.st, status);
        if (allocated_block !== want.blk)
          note_mismatch("allocated_block", want.blk, allocated_block);
        if (used_total !== want.tot) note_mismatch("used_total", want.tot, used_total);
      end
      replies_checked++;
    end
  end

  task automatic send_request(input logic k, input logic [BLK_W-1:0] blk);
    reply_t want;
    int     gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_enabled ? $urandom_range(0, 10) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    req_kind <= k;
    req_block <= blk;
    do @(posedge clk); while (in_stall);
    apply_request(k, blk, want);
    awaited_replies.push_back(want);
    requests_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_replies.size() != 0);
  endtask

  // all four registers, back to back; only called while the block is idle
  task automatic program_regs(input logic [TOT_W-1:0] bpg, input logic [TOT_W-1:0] fdb,
                              input logic [TOT_W-1:0] btot, input logic [TOT_W-1:0] gc);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_BLOCKS_PER_GROUP;
    cfg_data <= bpg;
    do @(posedge clk); while (!cfg_ready);
    reg_bpg = bpg[BPG_W-1:0];
    cfg_index <= CFG_FIRST_DATA_BLOCK;
    cfg_data <= fdb;
    do @(posedge clk); while (!cfg_ready);
    reg_fdb = fdb[BLK_W-1:0];
    cfg_index <= CFG_BLOCKS_TOTAL;
    cfg_data <= btot;
    do @(posedge clk); while (!cfg_ready);
    reg_btotal = btot;
    cfg_index <= CFG_GROUP_COUNT;
    cfg_data <= gc;
    do @(posedge clk); while (!cfg_ready);
    reg_gcount = gc[GCNT_W-1:0];
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic send_random_item(input int alloc_pct);
    int               pick;
    logic [BLK_W-1:0] blk;
    blk = BLK_W'($urandom_range(0, 16'hFFFF));
    if ($urandom_range(0, 99) < alloc_pct) begin
      send_request(KIND_ALLOC, blk);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 70 && live_locs.size() != 0)
        blk = block_of(live_locs[$urandom_range(0, live_locs.size() - 1)]);
      else if (pick < 85 && freed_locs.size() != 0)
        blk = block_of(freed_locs[$urandom_range(0, freed_locs.size() - 1)]);
      send_request(KIND_FREE, blk);
    end
  endtask

  // reset register values: reuse of the lowest clear bit, range and double free
  task automatic test_reset_defaults();
    send_request(KIND_ALLOC, 16'hFFFF);
    send_request(KIND_ALLOC, 16'h0000);
    send_request(KIND_ALLOC, 16'h1234);
    send_request(KIND_FREE, 16'd0);
    send_request(KIND_FREE, 16'd1);
    send_request(KIND_FREE, 16'd1);
    send_request(KIND_FREE, 16'hFFFF);
    send_request(KIND_FREE, 16'hAAAA);
    send_request(KIND_FREE, 16'h5555);
    send_request(KIND_ALLOC, 16'h0000);
  endtask

  // register extremes: no groups searched, clamped sizes, empty range, freeing
  // outside the searched groups
  task automatic test_register_extremes();
    drain();
    program_regs(TOT_W'(BITS_PER_GROUP), 1, 65536, 0);
    send_request(KIND_ALLOC, 16'd0);
    drain();
    program_regs(0, 0, 0, 15);
    send_request(KIND_FREE, 16'd2);
    drain();
    program_regs(0, 0, 65536, 15);
    send_request(KIND_ALLOC, 16'd0);
    send_request(KIND_ALLOC, 16'd0);
    send_request(KIND_FREE, 16'd0);
    send_request(KIND_FREE, 16'd8);
    drain();
    program_regs(0, 0, 65536, 1);
    send_request(KIND_ALLOC, 16'd0);
    send_request(KIND_FREE, 16'd1);
    drain();
    program_regs(16383, 65535, 65536, 8);
    send_request(KIND_ALLOC, 16'd0);
    send_request(KIND_FREE, 16'd65534);
    send_request(KIND_FREE, 16'd65535);
  endtask

  task automatic test_random_traffic();
    int               p, i, n, pct, sel;
    logic [TOT_W-1:0] bpg_v, fdb_v, bt_v, gc_v;
    for (p = 0; p < 12; p++) begin
      drain();
      sel = $urandom_range(0, 19);
      if (sel < 14) bpg_v = TOT_W'($urandom_range(1, 24));
      else if (sel < 16) bpg_v = TOT_W'($urandom_range(25, 300));
      else if (sel == 16) bpg_v = 0;
      else if (sel == 17) bpg_v = TOT_W'(BITS_PER_GROUP);
      else if (sel == 18) bpg_v = TOT_W'($urandom_range(BITS_PER_GROUP + 1, 16383));
      else bpg_v = TOT_W'($urandom_range(301, BITS_PER_GROUP - 1));
      sel = $urandom_range(0, 9);
      if (sel < 6) fdb_v = TOT_W'($urandom_range(0, 3));
      else if (sel < 8) fdb_v = TOT_W'($urandom_range(0, 64));
      else if (sel == 8) fdb_v = 0;
      else fdb_v = TOT_W'($urandom_range(0, 65535));
      sel = $urandom_range(0, 9);
      if (sel < 6) bt_v = 65536;
      else if (sel < 8) bt_v = TOT_W'($urandom_range(16, 65536));
      else if (sel == 8) bt_v = 0;
      else bt_v = TOT_W'($urandom_range(0, 65536));
      sel = $urandom_range(0, 9);
      if (sel < 7) gc_v = TOT_W'($urandom_range(1, 8));
      else if (sel == 7) gc_v = 0;
      else gc_v = TOT_W'($urandom_range(9, 15));
      program_regs(bpg_v, fdb_v, bt_v, gc_v);
      gaps_enabled = (p % 4) != 3;
      pct = $urandom_range(25, 80);
      n = $urandom_range(80, 120);
      for (i = 0; i < n; i++) send_random_item(pct);
    end
    gaps_enabled = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering, so the input backs up
  task automatic test_backpressure();
    int i, r;
    drain();
    program_regs(4, 0, 65536, 8);
    gaps_enabled = 1'b0;
    for (r = 0; r < 2; r++) begin
      holds_asked <= holds_asked + 1;
      for (i = 0; i < 45; i++) send_random_item(60);
      drain();
    end
    gaps_enabled = 1'b1;
  endtask

  initial begin
    foreach (grp_used[g]) grp_used[g] = 0;
    foreach (status_tally[s]) status_tally[s] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited_replies.size() != 0) begin
      $display("%0d replies never arrived", awaited_replies.size());
      mismatches++;
    end
    $display("Covered %0d requests under %0d register settings, %0d replies checked,",
             requests_sent, settings_used, replies_checked);
    $display("  ok %0d, no free block %0d, out of range %0d, already free %0d; %0d mismatches",
             status_tally[ST_OK], status_tally[ST_NO_FREE], status_tally[ST_RANGE],
             status_tally[ST_ALREADY_FREE], mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== grouped_block_bitmap_allocator.f =====
rtl/core/gbba_pkg.sv
rtl/core/grouped_block_bitmap_allocator.sv
tb/tb_grouped_block_bitmap_allocator.sv
